// ===== hdl/tms_pkg.sv =====
package tms_pkg;

  // sizes of the machine
  localparam int TAPE_CELLS  = 1024;
  localparam int STATE_COUNT = 16;
  localparam int SYMBOL_BITS = 8;

  localparam int HEAD_W     = $clog2(TAPE_CELLS);
  localparam int LEN_W      = HEAD_W + 1;
  localparam int STATE_W    = $clog2(STATE_COUNT);
  localparam int SYM_W      = SYMBOL_BITS;
  localparam int TBL_AW     = STATE_W + SYM_W;
  localparam int TBL_DEPTH  = 1 << TBL_AW;
  localparam int CMD_W      = 3;
  localparam int MOVE_W     = 2;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STATE_COUNT;

  localparam logic [HEAD_W-1:0] HEAD_LAST    = HEAD_W'(TAPE_CELLS - 1);
  localparam logic [LEN_W-1:0]  LEN_FULL     = LEN_W'(TAPE_CELLS);
  localparam logic [TBL_AW-1:0] TBL_LAST     = TBL_AW'(TBL_DEPTH - 1);
  localparam logic [SYM_W-1:0]  BLANK_RESET  = SYM_W'(68);

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_CLEAR  = 3'd1,
    CMD_APPEND = 3'd2,
    CMD_START  = 3'd3,
    CMD_STEP   = 3'd4
  } cmd_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_RUNNING   = 3'd1,
    ST_ACCEPT    = 3'd2,
    ST_NO_TRANS  = 3'd3,
    ST_LEFT_EDGE = 3'd4,
    ST_TAPE_FULL = 3'd5,
    ST_HALTED    = 3'd6
  } status_e;

  // head moves, the unused code behaves as stay
  typedef enum logic [MOVE_W-1:0] {
    MV_LEFT  = 2'd0,
    MV_RIGHT = 2'd1,
    MV_STAY  = 2'd2
  } move_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START  = 2'd0,
    CFG_ACCEPT = 2'd1,
    CFG_BLANK  = 2'd2
  } cfg_e;

  // transition table entry
  typedef struct packed {
    logic               valid;
    logic [SYM_W-1:0]   wsym;
    logic [MOVE_W-1:0]  mv;
    logic [STATE_W-1:0] nxt;
  } entry_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_TAPE,
    S_STEP,
    S_BLANK
  } fsm_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CAPTURE,
    OP_CLEAR_TBL,
    OP_FIN_SIMPLE,
    OP_LOAD_RD,
    OP_LOAD_FIN,
    OP_TAPE_RD,
    OP_TBL_RD,
    OP_STEP_FIN,
    OP_STEP_EXT,
    OP_BLANK_FIN
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   fin;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             run_active;
    logic             entry_valid;
    logic             blank_needed;
    logic             out_free;
    logic             clr_last;
  } stat_t;

endpackage

// ===== hdl/tms_if.sv =====
interface tms_in_if import tms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [STATE_W-1:0]  state_index;
  logic [SYM_W-1:0]    read_symbol;
  logic [SYM_W-1:0]    write_symbol;
  logic [MOVE_W-1:0]   move;
  logic [STATE_W-1:0]  next_state;
  logic [SYM_W-1:0]    tape_symbol;

  modport source (
    output valid, command, state_index, read_symbol, write_symbol, move, next_state,
           tape_symbol,
    input  ready
  );
  modport sink (
    input  valid, command, state_index, read_symbol, write_symbol, move, next_state,
           tape_symbol,
    output ready
  );
endinterface

interface tms_out_if import tms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [STATE_W-1:0]  current_state;
  logic [HEAD_W-1:0]   head_position;
  logic [LEN_W-1:0]    tape_length;

  modport source (
    output valid, status, current_state, head_position, tape_length,
    input  ready
  );
  modport sink (
    input  valid, status, current_state, head_position, tape_length,
    output ready
  );
endinterface

// ===== hdl/tms_ctrl.sv =====
module tms_ctrl import tms_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  fsm_e state_q, state_d;

  // state register, reset starts the table clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '{op: OP_IDLE, fin: 1'b0};
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLR: begin
        ctrl_o.op = OP_CLEAR_TBL;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = OP_CAPTURE;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.cmd)
          CMD_LOAD: begin
            ctrl_o.op = OP_LOAD_RD;
            state_d   = S_LOAD;
          end
          CMD_STEP: begin
            if (stat_i.run_active) begin
              ctrl_o.op = OP_TAPE_RD;
              state_d   = S_TAPE;
            end else if (stat_i.out_free) begin
              ctrl_o  = '{op: OP_FIN_SIMPLE, fin: 1'b1};
              state_d = S_IDLE;
            end
          end
          default: begin
            if (stat_i.out_free) begin
              ctrl_o  = '{op: OP_FIN_SIMPLE, fin: 1'b1};
              state_d = S_IDLE;
            end
          end
        endcase
      end
      S_LOAD: begin
        if (stat_i.out_free) begin
          ctrl_o  = '{op: OP_LOAD_FIN, fin: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_TAPE: begin
        ctrl_o.op = OP_TBL_RD;
        state_d   = S_STEP;
      end
      S_STEP: begin
        // a right move onto the end of the tape needs a second write
        if (stat_i.blank_needed) begin
          ctrl_o.op = OP_STEP_EXT;
          state_d   = S_BLANK;
        end else if (stat_i.out_free) begin
          ctrl_o  = '{op: OP_STEP_FIN, fin: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_BLANK: begin
        if (stat_i.out_free) begin
          ctrl_o  = '{op: OP_BLANK_FIN, fin: 1'b1};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tms_datapath.sv =====
module tms_datapath import tms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [STATE_W-1:0]    state_index_i,
  input  logic [SYM_W-1:0]      read_symbol_i,
  input  logic [SYM_W-1:0]      write_symbol_i,
  input  logic [MOVE_W-1:0]     move_i,
  input  logic [STATE_W-1:0]    next_state_i,
  input  logic [SYM_W-1:0]      tape_symbol_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [STATE_W-1:0]    current_state_o,
  output logic [HEAD_W-1:0]     head_position_o,
  output logic [LEN_W-1:0]      tape_length_o
);

  // request fields held for the whole request
  logic [CMD_W-1:0]   cmd_q;
  logic [STATE_W-1:0] st_q;
  logic [SYM_W-1:0]   rd_q;
  logic [SYM_W-1:0]   wr_q;
  logic [MOVE_W-1:0]  mv_q;
  logic [STATE_W-1:0] nx_q;
  logic [SYM_W-1:0]   ts_q;

  // configuration
  logic [STATE_W-1:0]     start_q;
  logic [STATE_COUNT-1:0] accept_q;
  logic [SYM_W-1:0]       blank_q;

  // machine state
  logic [LEN_W-1:0]   len_q, len_d;
  logic [HEAD_W-1:0]  head_q, head_d;
  logic [STATE_W-1:0] mstate_q, mstate_d;
  logic               run_q, run_d;
  logic [TBL_AW-1:0]  clr_addr_q;

  // result register
  logic                out_valid_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [STATE_W-1:0]  out_state_q;
  logic [HEAD_W-1:0]   out_head_q;
  logic [LEN_W-1:0]    out_len_q;

  // memories
  logic [SYM_W-1:0] tape_mem [TAPE_CELLS];
  entry_t           tbl_mem  [TBL_DEPTH];
  logic [SYM_W-1:0] tape_rd_q;
  entry_t           tbl_rd_q;

  logic              tape_we, tape_re, tbl_we, tbl_re;
  logic [HEAD_W-1:0] tape_wa;
  logic [SYM_W-1:0]  tape_wd;
  logic [TBL_AW-1:0] tbl_wa, tbl_ra;
  entry_t            tbl_wd;

  status_e           status;
  logic [LEN_W-1:0]  head_ext, len_wr;
  logic [SYM_W-1:0]  cur_sym;
  logic              out_free, blank_needed, take_next;

  // derived values for the step
  assign head_ext     = {1'b0, head_q};
  assign len_wr       = (head_ext >= len_q) ? head_ext + LEN_W'(1) : len_q;
  assign cur_sym      = (head_ext >= len_q) ? blank_q : tape_rd_q;
  assign out_free     = !out_valid_q || out_ready_i;
  assign blank_needed = tbl_rd_q.valid && (tbl_rd_q.mv == MV_RIGHT) &&
                        (head_q != HEAD_LAST) && (head_ext + LEN_W'(1) == len_wr);

  assign stat_o = '{
    cmd:          cmd_q,
    run_active:   run_q,
    entry_valid:  tbl_rd_q.valid,
    blank_needed: blank_needed,
    out_free:     out_free,
    clr_last:     clr_addr_q == TBL_LAST
  };

  // operation decode
  always_comb begin
    len_d     = len_q;
    head_d    = head_q;
    mstate_d  = mstate_q;
    run_d     = run_q;
    status    = ST_DONE;
    take_next = 1'b0;
    tape_we   = 1'b0;
    tape_re   = 1'b0;
    tape_wa   = head_q;
    tape_wd   = tbl_rd_q.wsym;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    tbl_wa    = {st_q, rd_q};
    tbl_ra    = {st_q, rd_q};
    tbl_wd    = '{valid: 1'b1, wsym: wr_q, mv: mv_q, nxt: nx_q};
    unique case (ctrl_i.op)
      OP_IDLE, OP_CAPTURE: begin
      end
      OP_CLEAR_TBL: begin
        tbl_we = 1'b1;
        tbl_wa = clr_addr_q;
        tbl_wd = '0;
      end
      OP_FIN_SIMPLE: begin
        case (cmd_q)
          CMD_CLEAR: begin
            len_d  = '0;
            head_d = '0;
            run_d  = 1'b0;
          end
          CMD_APPEND: begin
            if (len_q < LEN_FULL) begin
              tape_we = 1'b1;
              tape_wa = len_q[HEAD_W-1:0];
              tape_wd = ts_q;
              len_d   = len_q + LEN_W'(1);
            end else begin
              status = ST_TAPE_FULL;
            end
          end
          CMD_START: begin
            mstate_d = start_q;
            head_d   = '0;
            run_d    = 1'b1;
            status   = ST_RUNNING;
          end
          CMD_STEP: begin
            status = ST_HALTED;
          end
          default: begin
          end
        endcase
      end
      OP_LOAD_RD: begin
        tbl_re = 1'b1;
      end
      OP_LOAD_FIN: begin
        // first load for a state and symbol wins
        tbl_we = !tbl_rd_q.valid;
      end
      OP_TAPE_RD: begin
        tape_re = 1'b1;
      end
      OP_TBL_RD: begin
        tbl_re = 1'b1;
        tbl_ra = {mstate_q, cur_sym};
      end
      OP_STEP_FIN: begin
        if (!tbl_rd_q.valid) begin
          run_d  = 1'b0;
          status = ST_NO_TRANS;
        end else begin
          tape_we = 1'b1;
          len_d   = len_wr;
          case (tbl_rd_q.mv)
            MV_LEFT: begin
              if (head_q == '0) begin
                run_d  = 1'b0;
                status = ST_LEFT_EDGE;
              end else begin
                head_d    = head_q - HEAD_W'(1);
                take_next = 1'b1;
              end
            end
            MV_RIGHT: begin
              if (head_q == HEAD_LAST) begin
                run_d  = 1'b0;
                status = ST_TAPE_FULL;
              end else begin
                head_d    = head_q + HEAD_W'(1);
                take_next = 1'b1;
              end
            end
            default: begin
              take_next = 1'b1;
            end
          endcase
        end
      end
      OP_STEP_EXT: begin
        tape_we = 1'b1;
        len_d   = len_wr;
        head_d  = head_q + HEAD_W'(1);
      end
      OP_BLANK_FIN: begin
        tape_we   = 1'b1;
        tape_wd   = blank_q;
        len_d     = head_ext + LEN_W'(1);
        take_next = 1'b1;
      end
      default: begin
      end
    endcase

    // enter the next state and check for acceptance
    if (take_next) begin
      mstate_d = tbl_rd_q.nxt;
      if (accept_q[tbl_rd_q.nxt]) begin
        run_d  = 1'b0;
        status = ST_ACCEPT;
      end else begin
        status = ST_RUNNING;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      head_q      <= '0;
      mstate_q    <= '0;
      run_q       <= 1'b0;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      start_q     <= '0;
      accept_q    <= '0;
      blank_q     <= BLANK_RESET;
    end else begin
      len_q    <= len_d;
      head_q   <= head_d;
      mstate_q <= mstate_d;
      run_q    <= run_d;
      if (ctrl_i.op == OP_CLEAR_TBL) clr_addr_q <= clr_addr_q + TBL_AW'(1);
      if (ctrl_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_START:  start_q  <= cfg_wdata_i[STATE_W-1:0];
          CFG_ACCEPT: accept_q <= cfg_wdata_i[STATE_COUNT-1:0];
          CFG_BLANK:  blank_q  <= cfg_wdata_i[SYM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // request capture and result snapshot
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_CAPTURE) begin
      cmd_q <= command_i;
      st_q  <= state_index_i;
      rd_q  <= read_symbol_i;
      wr_q  <= write_symbol_i;
      mv_q  <= move_i;
      nx_q  <= next_state_i;
      ts_q  <= tape_symbol_i;
    end
    if (ctrl_i.fin) begin
      out_status_q <= status;
      out_state_q  <= mstate_d;
      out_head_q   <= head_d;
      out_len_q    <= len_d;
    end
  end

  // tape memory
  always_ff @(posedge clk_i) begin
    if (tape_we) tape_mem[tape_wa] <= tape_wd;
    if (tape_re) tape_rd_q <= tape_mem[head_q];
  end

  // transition table memory
  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
    if (tbl_re) tbl_rd_q <= tbl_mem[tbl_ra];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign current_state_o = out_state_q;
  assign head_position_o = out_head_q;
  assign tape_length_o   = out_len_q;

endmodule

// ===== hdl/turing_machine_stepper.sv =====
// channel   dir  handshake      contents
// in_if     in   valid/ready    command, transition fields, tape symbol
// out_if    out  valid/ready    status, state, head position, tape length
// cfg       in   cfg_we_i       start state, accept mask, blank symbol
//
// clear, append, start and a step with no run finish in EXEC, a load in LOAD,
// a step in STEP (tape read, then table read), and in BLANK when a right move
// grows the tape; after reset a pass clears the table; no request is taken then
// one request at a time; a waiting result stalls only the finishing cycle
module turing_machine_stepper import tms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tms_in_if.sink                in_if,
  tms_out_if.source             out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  tms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // tape, table and machine registers
  tms_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .command_i       (in_if.command),
    .state_index_i   (in_if.state_index),
    .read_symbol_i   (in_if.read_symbol),
    .write_symbol_i  (in_if.write_symbol),
    .move_i          (in_if.move),
    .next_state_i    (in_if.next_state),
    .tape_symbol_i   (in_if.tape_symbol),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .status_o        (out_if.status),
    .current_state_o (out_if.current_state),
    .head_position_o (out_if.head_position),
    .tape_length_o   (out_if.tape_length)
  );

endmodule

// ===== hdl/tms_checker.sv =====
module tms_checker import tms_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [STATE_W-1:0]  current_state_i,
  input logic [HEAD_W-1:0]   head_position_i,
  input logic [LEN_W-1:0]    tape_length_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(current_state_i) && $stable(head_position_i) && $stable(tape_length_i))
    else $error("stalled result changed");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // head stays inside the tape in use or at cell 0, tape within capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (tape_length_i <= LEN_FULL) &&
      (({1'b0, head_position_i} < tape_length_i) || (head_position_i == '0)))
    else $error("head or tape length out of range");

endmodule

bind turing_machine_stepper tms_checker u_tms_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .status_i        (out_if.status),
  .current_state_i (out_if.current_state),
  .head_position_i (out_if.head_position),
  .tape_length_i   (out_if.tape_length)
);

// ===== dv/tms_predict_check.sv =====
`timescale 1ns / 1ps

module tms_predict_check import tms_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tms_in_if                     in_if,
  tms_out_if                    out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  // printing stops here, counting does not
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    status_e            status;
    logic [STATE_W-1:0] state;
    logic [HEAD_W-1:0]  head;
    logic [LEN_W-1:0]   length;
  } snapshot_t;

  // machine snapshots still owed by the block, oldest first
  snapshot_t owed_snapshots[$];

  // own copy of the machine
  logic [SYM_W-1:0]       tape_cells [TAPE_CELLS];
  entry_t                 rules [TBL_DEPTH];
  logic [LEN_W-1:0]       tape_len;
  logic [HEAD_W-1:0]      head_at;
  logic [STATE_W-1:0]     cur_state;
  logic                   running;
  logic [STATE_W-1:0]     start_reg;
  logic [STATE_COUNT-1:0] accept_reg;
  logic [SYM_W-1:0]       blank_reg;

  task automatic report_failure(input string what);
    if (fail_count_o < PRINT_CAP) $display("%0t ns  mismatch: %s", $time, what);
    fail_count_o++;
  endtask

  // one move of the machine
  function automatic status_e take_step();
    logic [SYM_W-1:0] sym;
    entry_t           rule;
    if (!running) return ST_HALTED;
    sym  = (LEN_W'(head_at) >= tape_len) ? blank_reg : tape_cells[head_at];
    rule = rules[{cur_state, sym}];
    if (!rule.valid) begin
      running = 1'b0;
      return ST_NO_TRANS;
    end
    tape_cells[head_at] = rule.wsym;
    if (LEN_W'(head_at) >= tape_len) tape_len = LEN_W'(head_at) + 1'b1;
    case (rule.mv)
      MV_LEFT: begin
        // falling off the left edge leaves head and state alone
        if (head_at == '0) begin
          running = 1'b0;
          return ST_LEFT_EDGE;
        end
        head_at--;
      end
      MV_RIGHT: begin
        if (head_at == HEAD_LAST) begin
          running = 1'b0;
          return ST_TAPE_FULL;
        end
        head_at++;
        // stepping onto the end of the tape grows it by one blank cell
        if (LEN_W'(head_at) >= tape_len) begin
          tape_cells[head_at] = blank_reg;
          tape_len            = LEN_W'(head_at) + 1'b1;
        end
      end
      default: ;
    endcase
    cur_state = rule.nxt;
    if (accept_reg[cur_state]) begin
      running = 1'b0;
      return ST_ACCEPT;
    end
    return ST_RUNNING;
  endfunction

  // effect of one accepted request
  function automatic snapshot_t apply_request();
    status_e           verdict;
    logic [MOVE_W-1:0] mv;
    verdict = ST_DONE;
    case (in_if.command)
      CMD_LOAD: begin
        // spare move code behaves as stay, first load for a slot wins
        mv = in_if.move;
        if (mv > MV_STAY) mv = MV_STAY;
        if (!rules[{in_if.state_index, in_if.read_symbol}].valid)
          rules[{in_if.state_index, in_if.read_symbol}] =
            '{valid: 1'b1, wsym: in_if.write_symbol, mv: mv, nxt: in_if.next_state};
      end
      CMD_CLEAR: begin
        tape_len = '0;
        head_at  = '0;
        running  = 1'b0;
      end
      CMD_APPEND: begin
        if (tape_len < LEN_FULL) begin
          tape_cells[tape_len[HEAD_W-1:0]] = in_if.tape_symbol;
          tape_len++;
        end else begin
          verdict = ST_TAPE_FULL;
        end
      end
      CMD_START: begin
        cur_state = start_reg;
        head_at   = '0;
        running   = 1'b1;
        verdict   = ST_RUNNING;
      end
      CMD_STEP: begin
        verdict = take_step();
      end
      default: ;
    endcase
    return '{verdict, cur_state, head_at, tape_len};
  endfunction

  // watch configuration, requests and results
  always @(posedge clk_i or negedge rst_ni) begin : track
    snapshot_t want;
    if (!rst_ni) begin
      foreach (rules[i]) rules[i] = '0;
      tape_len   = '0;
      head_at    = '0;
      cur_state  = '0;
      running    = 1'b0;
      start_reg  = '0;
      accept_reg = '0;
      blank_reg  = BLANK_RESET;
      owed_snapshots.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START:  start_reg  = cfg_wdata_i[STATE_W-1:0];
          CFG_ACCEPT: accept_reg = cfg_wdata_i[STATE_COUNT-1:0];
          CFG_BLANK:  blank_reg  = cfg_wdata_i[SYM_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) owed_snapshots = {owed_snapshots, apply_request()};
      if (out_if.valid && out_if.ready) begin
        if (owed_snapshots.size() == 0) begin
          report_failure($sformatf("result with no request pending, status %0d",
                                   out_if.status));
        end else begin
          want = owed_snapshots.pop_front();
          if (out_if.status !== want.status)
            report_failure($sformatf("status got %0d want %0d", out_if.status,
                                     want.status));
          if (out_if.current_state !== want.state)
            report_failure($sformatf("state got %0d want %0d", out_if.current_state,
                                     want.state));
          if (out_if.head_position !== want.head)
            report_failure($sformatf("head got %0d want %0d", out_if.head_position,
                                     want.head));
          if (out_if.tape_length !== want.length)
            report_failure($sformatf("tape length got %0d want %0d", out_if.tape_length,
                                     want.length));
        end
      end
      pending_o = owed_snapshots.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import tms_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int ITEM_TARGET  = 2000;
  localparam int IDLE_PCT     = 36;
  localparam int NOISE_PCT    = 6;
  localparam int DRAIN_CYCLES = 20;

  // command codes the block ignores, spare move code, state kept for the tape walk
  localparam logic [CMD_W-1:0]   CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0]   CMD_SPARE_HI = 3'd7;
  localparam logic [MOVE_W-1:0]  MV_SPARE     = 2'd3;
  localparam logic [STATE_W-1:0] WALK_STATE   = 4'd14;

  typedef struct packed {
    logic [CMD_W-1:0]   code;
    logic [STATE_W-1:0] owner_state;
    logic [SYM_W-1:0]   read_sym;
    logic [SYM_W-1:0]   write_sym;
    logic [MOVE_W-1:0]  head_move;
    logic [STATE_W-1:0] next_st;
    logic [SYM_W-1:0]   tape_sym;
  } req_t;

  logic                  clk_i  = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int sent_items  = 0;
  bit calm        = 1'b0;
  bit hold_req    = 1'b0;

  tms_in_if  in_if ();
  tms_out_if out_if ();

  turing_machine_stepper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tms_predict_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .out_if       (out_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (mismatches),
    .pending_o    (pending)
  );

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic req_t random_req();
    req_t r;
    r.code        = CMD_W'($urandom_range(0, CMD_SPARE_HI));
    r.owner_state = STATE_W'($urandom);
    r.read_sym    = SYM_W'($urandom);
    r.write_sym   = SYM_W'($urandom);
    r.head_move   = MOVE_W'($urandom);
    r.next_st     = STATE_W'($urandom);
    r.tape_sym    = SYM_W'($urandom);
    return r;
  endfunction

  function automatic req_t rule_req(input logic [STATE_W-1:0] st, input logic [SYM_W-1:0] rd,
                                    input logic [SYM_W-1:0] wr, input logic [MOVE_W-1:0] mv,
                                    input logic [STATE_W-1:0] nx);
    req_t r;
    r             = random_req();
    r.code        = CMD_LOAD;
    r.owner_state = st;
    r.read_sym    = rd;
    r.write_sym   = wr;
    r.head_move   = mv;
    r.next_st     = nx;
    return r;
  endfunction

  // any command other than a load, unused fields random
  function automatic req_t plain_req(input logic [CMD_W-1:0] code, input logic [SYM_W-1:0] sym);
    req_t r;
    r          = random_req();
    r.code     = code;
    r.tape_sym = sym;
    return r;
  endfunction

  // offer one request and wait for it to be taken
  task automatic issue(input req_t r);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= r.code;
    in_if.state_index  <= r.owner_state;
    in_if.read_symbol  <= r.read_sym;
    in_if.write_symbol <= r.write_sym;
    in_if.move         <= r.head_move;
    in_if.next_state   <= r.next_st;
    in_if.tape_symbol  <= r.tape_sym;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent_items++;
  endtask

  // occasionally slip a random request in front
  task automatic offer(input req_t r);
    if ($urandom_range(99) < NOISE_PCT) issue(random_req());
    issue(r);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [STATE_W-1:0] start_st,
                            input logic [STATE_COUNT-1:0] accept_bits,
                            input logic [SYM_W-1:0] blank_sym);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_START;
    cfg_wdata <= CFG_DATA_W'(start_st);
    @(negedge clk_i);
    cfg_idx   <= CFG_ACCEPT;
    cfg_wdata <= CFG_DATA_W'(accept_bits);
    @(negedge clk_i);
    cfg_idx   <= CFG_BLANK;
    cfg_wdata <= CFG_DATA_W'(blank_sym);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [SYM_W-1:0]       alpha [4];
    logic [STATE_W-1:0]     pool [4];
    logic [STATE_COUNT-1:0] accept_bits;
    logic [SYM_W-1:0]       blank_sym;
    int                     phase;
    int                     pick;

    in_if.valid        = 1'b0;
    in_if.command      = CMD_LOAD;
    in_if.state_index  = '0;
    in_if.read_symbol  = '0;
    in_if.write_symbol = '0;
    in_if.move         = MV_LEFT;
    in_if.next_state   = '0;
    in_if.tape_symbol  = '0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_START;
    cfg_wdata          = '0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: state 1 accepts, blank at its top value
    set_config('0, STATE_COUNT'(2), 8'hFF);
    issue(plain_req(CMD_STEP, 8'h00));
    issue(plain_req(CMD_SPARE_LO, 8'h00));
    issue(plain_req(CMD_SPARE_HI, 8'hFF));
    issue(rule_req(4'd0, 8'hFF, 8'hA5, MV_RIGHT, 4'd0));
    issue(rule_req(4'd0, 8'hFF, 8'h00, MV_LEFT, 4'd3));
    issue(rule_req(4'd0, 8'h00, 8'hFF, MV_SPARE, 4'd1));
    issue(rule_req(4'd15, 8'h00, 8'h5A, MV_LEFT, 4'd15));
    issue(rule_req(4'd0, 8'h80, 8'h80, MV_LEFT, 4'd15));
    // empty tape reads blank and grows on right moves
    issue(plain_req(CMD_START, 8'h00));
    issue(plain_req(CMD_STEP, 8'h00));
    issue(plain_req(CMD_STEP, 8'h00));
    issue(plain_req(CMD_APPEND, 8'h00));
    issue(rule_req(4'd1, 8'h7F, 8'h01, MV_RIGHT, 4'd2));
    issue(plain_req(CMD_STEP, 8'h00));
    issue(plain_req(CMD_STEP, 8'h00));
    issue(plain_req(CMD_STEP, 8'h00));
    // left edge
    issue(plain_req(CMD_CLEAR, 8'h00));
    issue(plain_req(CMD_APPEND, 8'h80));
    issue(plain_req(CMD_START, 8'h00));
    issue(plain_req(CMD_STEP, 8'h00));
    // no transition
    issue(plain_req(CMD_CLEAR, 8'h00));
    issue(plain_req(CMD_APPEND, 8'h7F));
    issue(plain_req(CMD_START, 8'h00));
    issue(plain_req(CMD_STEP, 8'h00));

    // walk right across the whole tape until it overflows, no idling here
    wait_idle();
    calm = 1'b1;
    set_config(WALK_STATE, '0, '0);
    for (int s = 0; s < (1 << SYM_W); s++)
      issue(rule_req(WALK_STATE, SYM_W'(s), SYM_W'($urandom), MV_RIGHT, WALK_STATE));
    issue(plain_req(CMD_CLEAR, 8'h00));
    issue(plain_req(CMD_START, 8'h00));
    repeat (TAPE_CELLS) issue(plain_req(CMD_STEP, 8'h00));
    issue(plain_req(CMD_APPEND, 8'h3C));
    calm = 1'b0;

    // random programs: load rules, fill tape, run
    phase = 0;
    while (sent_items < ITEM_TARGET) begin
      wait_idle();
      pick = $urandom_range(0, 5);
      pool[0] = STATE_W'($urandom);
      for (int k = 1; k < 4; k++) pool[k] = STATE_W'($urandom);
      case (pick)
        0:       accept_bits = '0;
        1:       accept_bits = '1;
        default: accept_bits = (STATE_COUNT'(1) << pool[$urandom_range(1, 3)])
                               | (STATE_COUNT'($urandom_range(0, 1)) << $urandom_range(0, 15));
      endcase
      case ($urandom_range(0, 3))
        0:       blank_sym = '0;
        1:       blank_sym = '1;
        default: blank_sym = SYM_W'($urandom);
      endcase
      alpha[0] = blank_sym;
      for (int k = 1; k < 4; k++) alpha[k] = SYM_W'($urandom);
      set_config(pool[0], accept_bits, blank_sym);
      if (phase == 1) hold_req = 1'b1;
      calm = (phase == 4);

      repeat ($urandom_range(4, 14))
        offer(rule_req(pool[$urandom_range(0, 3)], alpha[$urandom_range(0, 3)],
                       alpha[$urandom_range(0, 3)], MOVE_W'($urandom_range(0, MV_SPARE)),
                       pool[$urandom_range(0, 3)]));
      if ($urandom_range(9) != 0) offer(plain_req(CMD_CLEAR, 8'h00));
      repeat ($urandom_range(0, 8)) offer(plain_req(CMD_APPEND, alpha[$urandom_range(0, 3)]));
      offer(plain_req(CMD_START, 8'h00));
      repeat ($urandom_range(3, 40)) begin
        pick = $urandom_range(99);
        if (pick < 5)
          offer(plain_req(CMD_APPEND, alpha[$urandom_range(0, 3)]));
        else if (pick < 10)
          offer(rule_req(pool[$urandom_range(0, 3)], alpha[$urandom_range(0, 3)],
                         alpha[$urandom_range(0, 3)], MOVE_W'($urandom_range(0, MV_SPARE)),
                         pool[$urandom_range(0, 3)]));
        offer(plain_req(CMD_STEP, 8'h00));
      end
      phase++;
    end
    calm = 1'b0;

    // drain and give the verdict
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
